@@ sv/msgpack_integer_encoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the msgpack integer encoder
// all properties sample on i_clk and are off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef MSGPACK_INTEGER_ENCODER_CORE_MACROS_SVH
`define MSGPACK_INTEGER_ENCODER_CORE_MACROS_SVH

// same-cycle implication
`define MPIE_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPIE_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |=> (cons)) else $error(msg);

`endif

@@ sv/mpie_pkg.sv @@
// ----------------------------------------------------------------------------
// mpie_pkg
// shared types and constants of the msgpack integer encoder
// ----------------------------------------------------------------------------
`default_nettype none

package mpie_pkg;

    // messagepack type bytes
    localparam logic [7:0] FMT_U16 = 8'hcd;
    localparam logic [7:0] FMT_U32 = 8'hce;
    localparam logic [7:0] FMT_U64 = 8'hcf;
    localparam logic [7:0] FMT_I8  = 8'hd0;
    localparam logic [7:0] FMT_I16 = 8'hd1;
    localparam logic [7:0] FMT_I32 = 8'hd2;
    localparam logic [7:0] FMT_I64 = 8'hd3;

    // encoding mode
    localparam logic FUNC_UNSIGNED = 1'b0;

    // queue between classifier and serializer
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // classified item: first byte, payload length, payload left-aligned
    typedef struct packed {
        logic [7:0]  type_byte;
        logic [3:0]  nbytes;
        logic [63:0] payload;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/mpie_classify.sv @@
// ----------------------------------------------------------------------------
// mpie_classify
// picks the smallest messagepack integer format and left-aligns the payload
// ----------------------------------------------------------------------------
`default_nettype none

module mpie_classify
    import mpie_pkg::*;
(
    input  wire logic        i_func,
    input  wire logic [63:0] i_value,
    output t_entry           o_entry
);

    logic hi7_zero, hi16_zero, hi32_zero;
    logic hi5_ones, fits8, fits16, fits32;
    logic [7:0]  enc_type;
    logic [3:0]  enc_len;
    logic [63:0] enc_payload;

    assign hi7_zero  = (i_value[63:7] == '0);
    assign hi16_zero = (i_value[63:16] == '0);
    assign hi32_zero = (i_value[63:32] == '0);
    assign hi5_ones  = (i_value[63:5] == '1);
    // signed fits: all bits above the sign bit equal the sign bit
    assign fits8  = (i_value[63:7] == '0) || (i_value[63:7] == '1);
    assign fits16 = (i_value[63:15] == '0) || (i_value[63:15] == '1);
    assign fits32 = (i_value[63:31] == '0) || (i_value[63:31] == '1);

    always_comb begin
        enc_type = i_value[7:0];
        enc_len  = 4'd0;
        if (i_func == FUNC_UNSIGNED) begin
            priority if (hi7_zero) begin
                enc_type = i_value[7:0];
                enc_len  = 4'd0;
            end else if (hi16_zero) begin
                enc_type = FMT_U16;
                enc_len  = 4'd2;
            end else if (hi32_zero) begin
                enc_type = FMT_U32;
                enc_len  = 4'd4;
            end else begin
                enc_type = FMT_U64;
                enc_len  = 4'd8;
            end
        end else begin
            // fixint covers -32..127
            priority if (hi7_zero || hi5_ones) begin
                enc_type = i_value[7:0];
                enc_len  = 4'd0;
            end else if (fits8) begin
                enc_type = FMT_I8;
                enc_len  = 4'd1;
            end else if (fits16) begin
                enc_type = FMT_I16;
                enc_len  = 4'd2;
            end else if (fits32) begin
                enc_type = FMT_I32;
                enc_len  = 4'd4;
            end else begin
                enc_type = FMT_I64;
                enc_len  = 4'd8;
            end
        end
    end

    // payload moved to the top so the serializer always takes bits 63:56
    always_comb begin
        unique case (enc_len)
            4'd1:    enc_payload = {i_value[7:0], 56'd0};
            4'd2:    enc_payload = {i_value[15:0], 48'd0};
            4'd4:    enc_payload = {i_value[31:0], 32'd0};
            default: enc_payload = i_value;
        endcase
    end

    assign o_entry = {enc_type, enc_len, enc_payload};

endmodule

`default_nettype wire

@@ sv/mpie_queue.sv @@
// ----------------------------------------------------------------------------
// mpie_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
`default_nettype none

module mpie_queue
    import mpie_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_entry    i_wr_entry,
    output logic      o_full,
    input  wire logic i_rd,
    output logic      o_valid,
    output t_entry    o_rd_entry
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic                  do_wr, do_rd;

    assign o_full     = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_rd_entry = r_mem[r_rd_ptr];
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

endmodule

`default_nettype wire

@@ sv/mpie_serialize.sv @@
// ----------------------------------------------------------------------------
// mpie_serialize
// turns queued items into a byte stream held in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module mpie_serialize
    import mpie_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  t_entry          i_q_entry,
    output logic            o_q_rd,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    input  wire logic       i_out_take
);

    logic        r_busy, n_busy;
    logic [3:0]  r_rem, n_rem;
    logic [63:0] r_sh, n_sh;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        can_load;

    assign can_load    = !r_ovalid || i_out_take;
    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

    always_comb begin
        n_busy   = r_busy;
        n_rem    = r_rem;
        n_sh     = r_sh;
        n_ovalid = r_ovalid;
        n_byte   = r_byte;
        n_last   = r_last;
        o_q_rd   = 1'b0;
        if (can_load) begin
            n_ovalid = 1'b0;
            if (r_busy) begin
                // payload byte, most significant first
                n_ovalid = 1'b1;
                n_byte   = r_sh[63:56];
                n_last   = (r_rem == 4'd1);
                n_sh     = {r_sh[55:0], 8'd0};
                n_rem    = r_rem - 4'd1;
                n_busy   = (r_rem != 4'd1);
            end else if (i_q_valid) begin
                // type byte or fixint
                o_q_rd   = 1'b1;
                n_ovalid = 1'b1;
                n_byte   = i_q_entry.type_byte;
                n_last   = (i_q_entry.nbytes == 4'd0);
                n_sh     = i_q_entry.payload;
                n_rem    = i_q_entry.nbytes;
                n_busy   = (i_q_entry.nbytes != 4'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_sh   <= n_sh;
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

@@ sv/msgpack_integer_encoder_core.sv @@
// ----------------------------------------------------------------------------
// msgpack_integer_encoder_core
// messagepack encoder for one 64-bit integer, unsigned or signed
// ----------------------------------------------------------------------------
// Each pushed item (i_func, i_value) comes out as its messagepack encoding,
// one byte per popped item: the type byte first, then the payload
// big-endian, with o_last high on the final byte. Unsigned values 0..127 and
// signed values -32..127 are a single fixint byte; otherwise the smallest of
// uint16/uint32/uint64 (uint8 is never used) or int8/int16/int32/int64 is
// chosen, so an item takes 1, 2, 3, 5 or 9 bytes. Sustained throughput is
// one byte per clock while pop stays high and items are waiting; the
// serializer moves one byte per cycle into the output register. The input
// side classifies in the cycle of the push and files the item into a
// two-deep queue, so pushes are taken back to back while earlier items are
// still being sent, until the queue is full. With an idle output the item
// is first written into the queue, then its first byte is loaded into the
// output register, from which it can be popped.
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_integer_encoder_core
    import mpie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input side
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_func,
    input  wire logic [63:0] i_value,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);

    // classified item headed for the queue
    t_entry cls_entry;
    // head of the queue, seen by the serializer
    t_entry q_entry;
    logic   q_valid;
    logic   q_rd;
    logic   out_valid;

    // front: format selection and payload alignment
    mpie_classify u_classify (
        .i_func  (i_func),
        .i_value (i_value),
        .o_entry (cls_entry)
    );

    // decoupling queue, full stalls the pusher
    mpie_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (push),
        .i_wr_entry (cls_entry),
        .o_full     (full),
        .i_rd       (q_rd),
        .o_valid    (q_valid),
        .o_rd_entry (q_entry)
    );

    // back: byte serializer with registered output
    mpie_serialize u_serialize (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_rd      (q_rd),
        .o_out_valid (out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .i_out_take  (pop)
    );

    // output looks like a queue: empty while no byte is waiting
    assign empty = !out_valid;

endmodule

`default_nettype wire

@@ sv/mpie_checker.sv @@
// ----------------------------------------------------------------------------
// mpie_checker
// port-level checks of the encoder byte stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "msgpack_integer_encoder_core_macros.svh"

module mpie_checker
    import mpie_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last
);

    logic       r_at_start;
    logic [3:0] r_rem;
    logic       typed;
    logic [3:0] type_len;
    logic       take;
    logic       stall;

    assign take  = pop && !empty;
    assign stall = !empty && !pop;
    assign typed = (o_out_byte >= FMT_U16) && (o_out_byte <= FMT_I64);

    always_comb begin
        unique case (o_out_byte)
            FMT_U16: type_len = 4'd2;
            FMT_U32: type_len = 4'd4;
            FMT_U64: type_len = 4'd8;
            FMT_I8:  type_len = 4'd1;
            FMT_I16: type_len = 4'd2;
            FMT_I32: type_len = 4'd4;
            FMT_I64: type_len = 4'd8;
            default: type_len = 4'd0;
        endcase
    end

    // track where in an encoding the stream stands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_rem      <= 4'd0;
        end else if (take) begin
            r_at_start <= o_last;
            r_rem      <= r_at_start ? type_len : r_rem - 4'd1;
        end
    end

    `MPIE_ASSERT_NEXT(a_hold, stall, !empty && $stable(o_out_byte) && $stable(o_last), "held")
    `MPIE_ASSERT_NOW(a_first_last, take && r_at_start, o_last == !typed, "first last")
    `MPIE_ASSERT_NOW(a_payload_last, take && !r_at_start, o_last == (r_rem == 4'd1), "length")

endmodule

bind msgpack_integer_encoder_core mpie_checker u_mpie_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);

`default_nettype wire
